// ----- sv/uisr_pkg.sv -----
// Package: types, constants and UTF-8 helper functions for the sanitizer.
package uisr_pkg;

    localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
    localparam logic [7:0]  CONT_MARK    = 8'h80;
    localparam logic [7:0]  LEAD2_MARK   = 8'hC0;
    localparam logic [7:0]  LEAD3_MARK   = 8'hE0;
    localparam logic [7:0]  LEAD4_MARK   = 8'hF0;
    localparam logic [7:0]  MASK3        = 8'hE0;
    localparam logic [7:0]  MASK4        = 8'hF0;
    localparam logic [7:0]  MASK5        = 8'hF8;
    localparam logic [20:0] MIN_CP2      = 21'h80;
    localparam logic [20:0] MIN_CP3      = 21'h800;
    localparam logic [20:0] SURR_LO      = 21'hD800;
    localparam logic [20:0] SURR_HI      = 21'hDFFF;
    localparam logic [20:0] MIN_CP4      = 21'h10000;
    localparam logic [20:0] MAX_CP       = 21'h10FFFF;
    localparam logic [20:0] RESET_REPL   = 21'hFFFD;

    // One self-contained byte run handed from the front to the back.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
        logic            stream_end;
    } run_t;

    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] n;
        n = 3'd0;
        if ((c & MASK3) == LEAD2_MARK)
            n = 3'd2;
        else if ((c & MASK4) == LEAD3_MARK)
            n = 3'd3;
        else if ((c & MASK5) == LEAD4_MARK)
            n = 3'd4;
        return n;
    endfunction

    function automatic logic [2:0] repl_length(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < MIN_CP2)
            n = 3'd1;
        else if (cp < MIN_CP3)
            n = 3'd2;
        else if (cp < MIN_CP4)
            n = 3'd3;
        else
            n = 3'd4;
        return n;
    endfunction

    function automatic logic [7:0] repl_byte(input logic [20:0] cp, input logic [1:0] j);
        logic [7:0] b;
        b = cp[7:0];
        if (cp >= MIN_CP2 && cp < MIN_CP3)
        begin
            b = (j == 2'd0) ? (LEAD2_MARK | {3'b000, cp[10:6]}) : (CONT_MARK | {2'b00, cp[5:0]});
        end
        else if (cp >= MIN_CP3 && cp < MIN_CP4)
        begin
            case (j)
                2'd0:    b = LEAD3_MARK | {4'h0, cp[15:12]};
                2'd1:    b = CONT_MARK | {2'b00, cp[11:6]};
                default: b = CONT_MARK | {2'b00, cp[5:0]};
            endcase
        end
        else if (cp >= MIN_CP4)
        begin
            case (j)
                2'd0:    b = LEAD4_MARK | {5'h00, cp[20:18]};
                2'd1:    b = CONT_MARK | {2'b00, cp[17:12]};
                2'd2:    b = CONT_MARK | {2'b00, cp[11:6]};
                default: b = CONT_MARK | {2'b00, cp[5:0]};
            endcase
        end
        return b;
    endfunction

endpackage

// ----- sv/uisr_if.sv -----
// Interfaces: raw input byte channel and sanitized output byte channel.
interface uisr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

interface uisr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       output_end;

    modport source (output valid, output out_byte, output run_last, output output_end,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input output_end,
                  output ready);
endinterface

// ----- sv/utf8_invalid_sequence_replacer.sv -----
// Top level of the UTF-8 sanitizer: replacement register, front, queue and back.
//
// raw carries one input byte per word with stream_end on the final byte of a
// stream; clean carries one sanitized UTF-8 byte per word. run_last marks the
// last output word caused by one input word, output_end the last output word
// of a stream. Both channels move a word at a rising edge with valid and
// ready high. cfg_we/cfg_wdata write the replacement codepoint (reset 0xFFFD)
// and must only be used while no word is in flight.
// A word that completes a run is written into the run queue, and its first output
// word then passes through the output register before it appears on clean.
// The back emits one output byte per cycle while the output register is free or
// clean takes its word, so bytes that pass unchanged flow at one word per cycle;
// a replacement is emitted one encoded byte at a time, and the raw side stalls
// once the two-entry run queue fills.
// Lead bytes that wait for followers produce no output until completed or until stream_end.
// Reset empties the pending buffer, the run queue and the output register.
// When clean stalls, the output register holds its word and the back and the
// queue stop; raw keeps being taken until the queue is full.
module utf8_invalid_sequence_replacer (
    input  logic        clk,
    input  logic        rst_n,
    uisr_byte_if.sink   raw,
    uisr_out_if.source  clean,
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata
);
    import uisr_pkg::*;

    logic [20:0] repl_code_reg;
    logic        q_full;
    logic        push;
    run_t        push_data;
    logic        pop;
    logic        head_valid;
    run_t        head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_code_reg <= RESET_REPL;
        else if (cfg_we)
            repl_code_reg <= cfg_wdata;
    end

    uisr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw       (raw),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    uisr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    uisr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .repl_code  (repl_code_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .clean      (clean)
    );

endmodule

// ----- sv/uisr_front.sv -----
// Front: accepts raw bytes, gathers multi-byte sequences and issues runs.
module uisr_front (
    input  logic          clk,
    input  logic          rst_n,
    uisr_byte_if.sink     raw,
    input  logic          q_full,
    output logic          push,
    output uisr_pkg::run_t push_data
);
    import uisr_pkg::*;

    logic [2:0][7:0] pending_bytes_reg;
    logic [1:0]      pending_count_reg;
    logic [1:0]      pending_count_next;
    logic [2:0]      needed_length_reg;
    logic [2:0]      needed_length_next;
    logic            accept;
    logic            store;
    logic [2:0]      len;
    logic [2:0]      need;
    logic [3:0][7:0] run_bytes;

    assign raw.ready = !q_full;
    assign accept    = raw.valid && raw.ready;
    assign len       = {1'b0, pending_count_reg} + 3'd1;
    assign need      = lead_length(raw.data_byte);

    always_comb
    begin
        run_bytes = {pending_bytes_reg[2], pending_bytes_reg[1],
                     pending_bytes_reg[0], raw.data_byte};
        run_bytes[0] = pending_bytes_reg[0];
        run_bytes[1] = pending_bytes_reg[1];
        run_bytes[2] = pending_bytes_reg[2];
        run_bytes[3] = 8'h00;
        run_bytes[pending_count_reg] = raw.data_byte;
    end

    always_comb
    begin
        push               = 1'b0;
        store              = 1'b0;
        pending_count_next = pending_count_reg;
        needed_length_next = needed_length_reg;
        if (accept)
        begin
            if (raw.stream_end)
            begin
                push               = 1'b1;
                pending_count_next = 2'd0;
                needed_length_next = 3'd0;
            end
            else if (pending_count_reg == 2'd0)
            begin
                if (need == 3'd0)
                begin
                    push = 1'b1;
                end
                else
                begin
                    store              = 1'b1;
                    pending_count_next = 2'd1;
                    needed_length_next = need;
                end
            end
            else if (len >= needed_length_reg)
            begin
                push               = 1'b1;
                pending_count_next = 2'd0;
                needed_length_next = 3'd0;
            end
            else
            begin
                store              = 1'b1;
                pending_count_next = len[1:0];
            end
        end
    end

    assign push_data.bytes      = run_bytes;
    assign push_data.len        = len;
    assign push_data.stream_end = raw.stream_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_count_reg <= 2'd0;
            needed_length_reg <= 3'd0;
        end
        else
        begin
            pending_count_reg <= pending_count_next;
            needed_length_reg <= needed_length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
            pending_bytes_reg[pending_count_reg] <= raw.data_byte;
    end

endmodule

// ----- sv/uisr_queue.sv -----
// Two-entry run queue between the front and the back.
module uisr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  uisr_pkg::run_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output uisr_pkg::run_t head
);
    import uisr_pkg::*;

    run_t       mem_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("run queue written while full");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("run queue count out of range");
`endif

endmodule

// ----- sv/uisr_back.sv -----
// Back: walks one run, emitting passed bytes or replacement bytes one a cycle unless clean stalls.
module uisr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [20:0]    repl_code,
    input  logic           head_valid,
    input  uisr_pkg::run_t head,
    output logic           pop,
    uisr_out_if.source     clean
);
    import uisr_pkg::*;

    logic [1:0]  i_reg;
    logic [1:0]  i_next;
    logic [1:0]  j_reg;
    logic [1:0]  j_next;
    logic        out_vld_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_end_reg;

    logic [7:0]  c;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [2:0]  need;
    logic        fits;
    logic        seq_ok;
    logic [20:0] cp;
    logic [2:0]  unit_len;
    logic [2:0]  adv;
    logic [7:0]  emit_byte;
    logic        unit_last;
    logic        run_last_c;
    logic        emit;

    assign c    = head.bytes[i_reg];
    assign b1   = head.bytes[i_reg + 2'd1];
    assign b2   = head.bytes[i_reg + 2'd2];
    assign b3   = head.bytes[i_reg + 2'd3];
    assign need = lead_length(c);
    assign fits = (need != 3'd0) && (({1'b0, i_reg} + need) <= head.len);

    always_comb
    begin
        case (need)
            3'd2:
            begin
                cp     = {10'd0, c[4:0], b1[5:0]};
                seq_ok = cp >= MIN_CP2;
            end
            3'd3:
            begin
                cp     = {5'd0, c[3:0], b1[5:0], b2[5:0]};
                seq_ok = (cp >= MIN_CP3) && ((cp < SURR_LO) || (cp > SURR_HI));
            end
            default:
            begin
                cp     = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
                seq_ok = (cp >= MIN_CP4) && (cp <= MAX_CP);
            end
        endcase
    end

    always_comb
    begin
        adv = fits ? need : 3'd1;
        if (c < ASCII_LIMIT)
        begin
            unit_len  = 3'd1;
            emit_byte = c;
        end
        else if (fits && seq_ok)
        begin
            unit_len  = need;
            emit_byte = head.bytes[i_reg + j_reg];
        end
        else
        begin
            unit_len  = repl_length(repl_code);
            emit_byte = repl_byte(repl_code, j_reg);
        end
    end

    assign unit_last  = ({1'b0, j_reg} == unit_len - 3'd1);
    assign run_last_c = unit_last && (({1'b0, i_reg} + adv) >= head.len);
    assign emit       = head_valid && (!out_vld_reg || clean.ready);
    assign pop        = emit && run_last_c;

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (emit)
        begin
            if (run_last_c)
            begin
                i_next = 2'd0;
                j_next = 2'd0;
            end
            else if (unit_last)
            begin
                i_next = i_reg + adv[1:0];
                j_next = 2'd0;
            end
            else
            begin
                j_next = j_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg       <= 2'd0;
            j_reg       <= 2'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            i_reg <= i_next;
            j_reg <= j_next;
            if (emit)
                out_vld_reg <= 1'b1;
            else if (clean.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= run_last_c;
            out_end_reg  <= run_last_c && head.stream_end;
        end
    end

    assign clean.valid      = out_vld_reg;
    assign clean.out_byte   = out_byte_reg;
    assign clean.run_last   = out_last_reg;
    assign clean.output_end = out_end_reg;

`ifndef ASSERT_OFF
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("run popped from empty queue");
    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        emit && run_last_c |=> (i_reg == 2'd0) && (j_reg == 2'd0))
        else $error("run position not cleared after last word");
    a_mid_run_head: assert property (@(posedge clk) disable iff (!rst_n)
        (i_reg != 2'd0) || (j_reg != 2'd0) |-> head_valid)
        else $error("run in progress without a queued run");
`endif

endmodule

// ----- bench/tb.sv -----
// Testbench for utf8_invalid_sequence_replacer: directed and random byte streams.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SETTLE_TICKS = 12;
    localparam int unsigned MAX_WORDS    = 16;
    localparam int unsigned SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       output_end;
    } clean_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [20:0] cfg_wdata;

    uisr_byte_if raw ();
    uisr_out_if  clean ();

    utf8_invalid_sequence_replacer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw       (raw),
        .clean     (clean),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Mirror of the sanitizer state.
    logic [20:0] repl_cp;
    logic [7:0]  held_bytes [3];
    int unsigned held_count;
    int unsigned seq_length;

    clean_word_t step_words [$];
    clean_word_t expected_words [$];
    clean_word_t seen_word;
    clean_word_t wanted_word;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned send_idle_pct = 19;
    int unsigned recv_idle_pct = 68;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned sequence_length(input logic [7:0] c);
        if (c[7:5] == 3'b110)
            return 2;
        if (c[7:4] == 4'b1110)
            return 3;
        if (c[7:3] == 5'b11110)
            return 4;
        return 0;
    endfunction

    function automatic void emit(input logic [7:0] b);
        clean_word_t w;
        w.out_byte   = b;
        w.run_last   = 1'b0;
        w.output_end = 1'b0;
        if (step_words.size() < MAX_WORDS)
            step_words = {step_words, w};
    endfunction

    // The replacement is encoded by its size alone, with no range check.
    function automatic void emit_replacement();
        if (repl_cp < 21'h80)
            emit(repl_cp[7:0]);
        else if (repl_cp < 21'h800)
        begin
            emit({3'b110, repl_cp[10:6]});
            emit({2'b10, repl_cp[5:0]});
        end
        else if (repl_cp < 21'h10000)
        begin
            emit({4'b1110, repl_cp[15:12]});
            emit({2'b10, repl_cp[11:6]});
            emit({2'b10, repl_cp[5:0]});
        end
        else
        begin
            emit({5'b11110, repl_cp[20:18]});
            emit({2'b10, repl_cp[17:12]});
            emit({2'b10, repl_cp[11:6]});
            emit({2'b10, repl_cp[5:0]});
        end
    endfunction

    function automatic void sanitize_run(input logic [3:0][7:0] run, input int unsigned len);
        int unsigned i;
        int unsigned need;
        logic [20:0] cp;
        bit ok;
        i = 0;
        while (i < len)
        begin
            need = sequence_length(run[i]);
            if (run[i] < 8'h80)
            begin
                emit(run[i]);
                i = i + 1;
            end
            else if (need != 0 && i + need <= len)
            begin
                case (need)
                    2:
                    begin
                        cp = {10'd0, run[i][4:0], run[i + 1][5:0]};
                        ok = cp >= 21'h80;
                    end
                    3:
                    begin
                        cp = {5'd0, run[i][3:0], run[i + 1][5:0], run[i + 2][5:0]};
                        ok = cp >= 21'h800 && (cp < 21'hD800 || cp > 21'hDFFF);
                    end
                    default:
                    begin
                        cp = {run[i][2:0], run[i + 1][5:0], run[i + 2][5:0],
                              run[i + 3][5:0]};
                        ok = cp >= 21'h10000 && cp <= 21'h10FFFF;
                    end
                endcase
                if (ok)
                begin
                    for (int unsigned k = 0; k < need; k++)
                        emit(run[i + k]);
                end
                else
                    emit_replacement();
                i = i + need;
            end
            else
            begin
                emit_replacement();
                i = i + 1;
            end
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic last);
        logic [3:0][7:0] run;
        int unsigned len;
        step_words.delete();
        run = '0;
        for (int unsigned k = 0; k < held_count; k++)
            run[k] = held_bytes[k];
        run[held_count] = b;
        len = held_count + 1;
        if (last)
        begin
            // At the end of the stream the held bytes and the last byte are sanitized as one run, complete or not.
            sanitize_run(run, len);
            held_count = 0;
            seq_length = 0;
        end
        else if (held_count == 0)
        begin
            if (sequence_length(b) == 0)
                sanitize_run(run, 1);
            else
            begin
                held_bytes[0] = b;
                held_count = 1;
                seq_length = sequence_length(b);
            end
        end
        else if (len >= seq_length)
        begin
            sanitize_run(run, len);
            held_count = 0;
            seq_length = 0;
        end
        else
        begin
            held_bytes[held_count] = b;
            held_count = held_count + 1;
        end
        if (step_words.size() > 0)
        begin
            step_words[step_words.size() - 1].run_last = 1'b1;
            step_words[step_words.size() - 1].output_end = last;
        end
        expected_words = {expected_words, step_words};
    endfunction

    function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    task automatic report_mismatch(input string what, input clean_word_t want,
                                   input clean_word_t got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display({"%0t: %s: expected byte %02h run_last %0b output_end %0b, ",
                      "got byte %02h run_last %0b output_end %0b"},
                     $time, what, want.out_byte, want.run_last, want.output_end,
                     got.out_byte, got.run_last, got.output_end);
    endtask

    // Every word leaving the block is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && clean.valid && clean.ready)
        begin
            seen_word = {clean.out_byte, clean.run_last, clean.output_end};
            if (expected_words.size() == 0)
                report_mismatch("word with nothing expected", '0, seen_word);
            else
            begin
                wanted_word = expected_words.pop_front();
                if (seen_word !== wanted_word)
                    report_mismatch("wrong word", wanted_word, seen_word);
            end
        end
    end

    always @(posedge clk)
        clean.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[utf8_invalid_sequence_replacer] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            raw.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        raw.valid      <= 1'b1;
        raw.data_byte  <= b;
        raw.stream_end <= last;
        @(posedge clk);
        while (!raw.ready)
            @(posedge clk);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic settle();
        raw.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_replacement(input logic [20:0] code);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge clk);
        cfg_we    <= 1'b0;
        repl_cp = code;
    endtask

    task automatic test_valid_sequences();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        // Highest codepoint that is still legal.
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_invalid_sequences();
        // Overlong two-byte form.
        send_byte(8'hC1, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Surrogate.
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        // Above the last Unicode codepoint.
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // Stray continuation byte and a byte that can never lead.
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_stream_end();
        // Truncated sequence: the lead is replaced and the rest is taken afresh.
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h41, 1'b1);
        // Lead byte as the final byte of a stream.
        send_byte(8'hC3, 1'b1);
    endtask

    task automatic test_replacement_code();
        logic [20:0] codes [5] = '{21'h000000, 21'h000800, 21'h00D800,
                                   21'h10FFFF, 21'h1FFFFF};
        foreach (codes[k])
        begin
            settle();
            write_replacement(codes[k]);
            send_byte(8'hFF, 1'b1);
        end
    endtask

    task automatic send_random_sequence();
        int unsigned kind;
        int unsigned need;
        int unsigned followers;
        logic [7:0] lead;
        kind = $urandom_range(99);
        if (kind < 20)
            send_byte(rand_byte(0, 8'h7F), $urandom_range(99) < 4);
        else if (kind < 88)
        begin
            need = $urandom_range(4, 2);
            case (need)
                2: lead = rand_byte(8'hC0, 8'hDF);
                3: lead = ($urandom_range(3) == 0) ? 8'hE0 :
                          ($urandom_range(2) == 0) ? 8'hED : rand_byte(8'hE0, 8'hEF);
                default: lead = ($urandom_range(2) == 0) ? 8'hF0 :
                                ($urandom_range(1) == 0) ? 8'hF4 : rand_byte(8'hF0, 8'hF7);
            endcase
            // Some sequences are cut short before the next one starts.
            followers = (kind < 76) ? need - 1 : $urandom_range(need - 2);
            send_byte(lead, $urandom_range(99) < 4);
            for (int unsigned k = 0; k < followers; k++)
                send_byte(($urandom_range(9) == 0) ? rand_byte(0, 255)
                                                   : rand_byte(8'h80, 8'hBF),
                          $urandom_range(99) < 4);
        end
        else
            send_byte(rand_byte(0, 255), $urandom_range(99) < 4);
    endtask

    task automatic test_random_traffic(input int unsigned items, input int unsigned send_pct,
                                       input int unsigned recv_pct, input logic [20:0] code);
        int unsigned first;
        bit paused;
        settle();
        write_replacement(code);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - first < items)
        begin
            if (!paused && bytes_sent - first >= items / 2)
            begin
                // Let the output side run dry once in the middle of a stream.
                settle();
                paused = 1'b1;
            end
            send_random_sequence();
        end
        send_byte(rand_byte(0, 8'h7F), 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        raw.valid = 1'b0;
        raw.data_byte = 8'h00;
        raw.stream_end = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 21'd0;
        repl_cp = 21'h00FFFD;
        held_count = 0;
        seq_length = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_sequences();
        test_invalid_sequences();
        test_stream_end();
        test_replacement_code();
        test_random_traffic(130, 19, 68, 21'h0007FF);
        test_random_traffic(130, 68, 19, 21'h010000);
        test_random_traffic(130, 0, 0, 21'($urandom_range(21'h10FFFF)));
        settle();

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("[utf8_invalid_sequence_replacer] OK");
        else
            $display("[utf8_invalid_sequence_replacer] ERROR");
        $finish;
    end

endmodule
